// ===== hdl/rau_pkg.sv =====
// rau_pkg: shared types and codes for the rational arithmetic unit
// used by rau_front, rau_queue, rau_iter, rau_back and the top level
package rau_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int Q_DEPTH   = 2;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_SIMP = 3'd4;
  localparam logic [2:0] OP_EQ   = 3'd5;

  typedef enum logic [2:0] {
    K_DIRECT = 3'd0,
    K_LCM    = 3'd1,
    K_MUL    = 3'd2,
    K_SIMP   = 3'd3,
    K_EQ     = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  sub;
    logic  st;
  } entry_ctl_t;

  typedef enum logic [1:0] {
    IT_MUL = 2'd0,
    IT_DIV = 2'd1,
    IT_GCD = 2'd2
  } iter_cmd_t;

  localparam int CTL_W = $bits(entry_ctl_t);

endpackage

// ===== hdl/rational_arithmetic_unit_top.sv =====
// rational_arithmetic_unit_top: fraction add, subtract, multiply, divide,
// simplify and equality test; uses rau_pkg, rau_front, rau_queue, rau_back
//
// Input channel in_valid/in_stall carries op and fractions a and b; each
// item gives one result on out_valid/out_stall: res_num, res_den, is_equal
// and status (zero denominator in an operand or in the result).
// The front checks and sorts an item in the cycle it is taken and puts it
// in a two-entry queue; in_stall is high only while that queue is full.
// The back works one item at a time through one shared bit-serial unit
// that does a WIDTH-step multiply, a WIDTH-step divide or a binary gcd of
// at most 4*WIDTH steps.
// Errors, equal-denominator add/sub and unused codes need no unit work;
// multiply/divide forms numerator and denominator products, simplify finds
// a gcd and, unless it is 0 or 1, divides both terms by it, equality
// simplifies both fractions, and add/sub with unequal denominators forms the lcm and scaled numerators.
// Results sit in an output register; while out_stall is high it holds and
// the queue still takes up to two more items.
// Synchronous active-low reset empties the queue and the output register.
module rational_arithmetic_unit_top #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_res_num,
  output logic [31:0] out_res_den,
  output logic        out_is_equal,
  output logic        out_status
);
  import rau_pkg::*;

  localparam int DW = CTL_W + 4 * WIDTH;

  entry_ctl_t       f_ctl, h_ctl;
  logic [WIDTH-1:0] f_an, f_ad, f_bn, f_bd;
  logic [WIDTH-1:0] h_an, h_ad, h_bn, h_bd;
  logic [DW-1:0]    h_data;
  logic             q_full, q_valid, q_pop;
  logic [WIDTH-1:0] r_num, r_den;

  rau_front #(.WIDTH(WIDTH)) u_front (
    .op    (in_op),
    .a_num (in_a_num),
    .a_den (in_a_den),
    .b_num (in_b_num),
    .b_den (in_b_den),
    .ctl   (f_ctl),
    .an_o  (f_an),
    .ad_o  (f_ad),
    .bn_o  (f_bn),
    .bd_o  (f_bd)
  );

  rau_queue #(.DW(DW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_data  ({f_ctl, f_an, f_ad, f_bn, f_bd}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (h_data)
  );

  assign in_stall = q_full;
  assign {h_ctl, h_an, h_ad, h_bn, h_bd} = h_data;

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ctl     (h_ctl),
    .q_an      (h_an),
    .q_ad      (h_ad),
    .q_bn      (h_bn),
    .q_bd      (h_bd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_num   (r_num),
    .out_den   (r_den),
    .out_eq    (out_is_equal),
    .out_st    (out_status)
  );

  assign out_res_num = 32'($signed(r_num));
  assign out_res_den = 32'($signed(r_den));

endmodule

// ===== hdl/rau_front.sv =====
// rau_front: narrows operands, checks for zero denominators, adds or subtracts
// over equal denominators and sorts items by kind of work; depends on rau_pkg
module rau_front #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic [2:0]          op,
  input  logic [31:0]         a_num,
  input  logic [31:0]         a_den,
  input  logic [31:0]         b_num,
  input  logic [31:0]         b_den,
  output rau_pkg::entry_ctl_t ctl,
  output logic [WIDTH-1:0]    an_o,
  output logic [WIDTH-1:0]    ad_o,
  output logic [WIDTH-1:0]    bn_o,
  output logic [WIDTH-1:0]    bd_o
);
  import rau_pkg::*;

  logic [WIDTH-1:0] an, ad, bn, bd;
  logic             zero;

  assign an = WIDTH'($signed(a_num));
  assign ad = WIDTH'($signed(a_den));
  assign bn = WIDTH'($signed(b_num));
  assign bd = WIDTH'($signed(b_den));

  assign zero = (op <= OP_EQ) && ((ad == '0) || ((op != OP_SIMP) && (bd == '0)));

  always_comb begin
    ctl.kind = K_DIRECT;
    ctl.sub  = (op == OP_SUB);
    ctl.st   = 1'b0;
    an_o = an;
    ad_o = ad;
    bn_o = bn;
    bd_o = bd;
    if (zero) begin
      an_o   = '0;
      ad_o   = '0;
      ctl.st = 1'b1;
    end else begin
      unique case (op)
        OP_ADD, OP_SUB: begin
          if (ad == bd) begin
            an_o = (op == OP_SUB) ? an - bn : an + bn;
          end else begin
            ctl.kind = K_LCM;
          end
        end
        OP_MUL: ctl.kind = K_MUL;
        OP_DIV: begin
          // cross terms: a_num*b_den over a_den*b_num
          ctl.kind = K_MUL;
          bn_o = bd;
          bd_o = bn;
        end
        OP_SIMP: ctl.kind = K_SIMP;
        OP_EQ:   ctl.kind = K_EQ;
        default: begin
          an_o = '0;
          ad_o = WIDTH'(1);
        end
      endcase
    end
  end

endmodule

// ===== hdl/rau_queue.sv =====
// rau_queue: short fifo of classified items between front and back
// depends on rau_pkg for the depth
module rau_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output logic [DW-1:0] head_data
);
  import rau_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [DW-1:0] mem_r [Q_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ===== hdl/rau_iter.sv =====
// rau_iter: shared bit-serial unit: shift-add multiply, restoring divide
// and binary gcd, one step per cycle; depends on rau_pkg
module rau_iter #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rau_pkg::iter_cmd_t cmd,
  input  logic [WIDTH-1:0]   x,
  input  logic [WIDTH-1:0]   y,
  output logic               done,
  output logic [WIDTH-1:0]   res
);
  import rau_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  iter_cmd_t        cmd_r;
  logic             busy_r, done_r;
  logic [WIDTH-1:0] a_r, b_r, acc_r, res_r;
  logic [CW-1:0]    cnt_r;

  logic [WIDTH-1:0] acc_add;
  logic [WIDTH:0]   remsh, remsub;
  logic             qbit;

  assign done = done_r;
  assign res  = res_r;

  assign acc_add = acc_r + (b_r[0] ? a_r : '0);
  assign remsh   = {acc_r, a_r[WIDTH-1]};
  assign remsub  = remsh - {1'b0, b_r};
  assign qbit    = !remsub[WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cmd_r  <= cmd;
        a_r    <= x;
        b_r    <= y;
        acc_r  <= '0;
        cnt_r  <= (cmd == IT_GCD) ? '0 : CW'(WIDTH);
      end else if (busy_r) begin
        case (cmd_r)
          IT_MUL: begin
            acc_r <= acc_add;
            a_r   <= a_r << 1;
            b_r   <= b_r >> 1;
            cnt_r <= cnt_r - CW'(1);
            if (cnt_r == CW'(1)) begin
              res_r  <= acc_add;
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          IT_DIV: begin
            acc_r <= qbit ? remsub[WIDTH-1:0] : remsh[WIDTH-1:0];
            a_r   <= {a_r[WIDTH-2:0], qbit};
            cnt_r <= cnt_r - CW'(1);
            if (cnt_r == CW'(1)) begin
              res_r  <= {a_r[WIDTH-2:0], qbit};
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            // binary gcd, common factors of two counted in cnt_r
            if (a_r == '0 || b_r == '0) begin
              res_r  <= (a_r | b_r) << cnt_r;
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else if (!a_r[0] && !b_r[0]) begin
              a_r   <= a_r >> 1;
              b_r   <= b_r >> 1;
              cnt_r <= cnt_r + CW'(1);
            end else if (!a_r[0]) begin
              a_r <= a_r >> 1;
            end else if (!b_r[0]) begin
              b_r <= b_r >> 1;
            end else if (a_r >= b_r) begin
              a_r <= a_r - b_r;
            end else begin
              b_r <= b_r - a_r;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== hdl/rau_back.sv =====
// rau_back: sequencer that carries out one queued item with rau_iter
// and holds the result register; depends on rau_pkg and rau_iter
module rau_back #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rau_pkg::entry_ctl_t q_ctl,
  input  logic [WIDTH-1:0]    q_an,
  input  logic [WIDTH-1:0]    q_ad,
  input  logic [WIDTH-1:0]    q_bn,
  input  logic [WIDTH-1:0]    q_bd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WIDTH-1:0]    out_num,
  output logic [WIDTH-1:0]    out_den,
  output logic                out_eq,
  output logic                out_st
);
  import rau_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_LG    = 16'h0002,
    S_LQ    = 16'h0004,
    S_LL    = 16'h0008,
    S_LPA   = 16'h0010,
    S_LDA   = 16'h0020,
    S_LPB   = 16'h0040,
    S_LDB   = 16'h0080,
    S_MN    = 16'h0100,
    S_MD    = 16'h0200,
    S_SG    = 16'h0400,
    S_SN    = 16'h0800,
    S_SD    = 16'h1000,
    S_SDONE = 16'h2000,
    S_FIN   = 16'h4000
  } state_t;

  function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
    mag = v[WIDTH-1] ? -v : v;
  endfunction

  state_t           state_r, state_nxt;
  logic             kick_r, kick_nxt, phase_r, sub_r;
  kind_t            kind_r;
  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r, w_r, l_r, t_r;
  logic [WIDTH-1:0] rn_r, rd_r;
  logic             eq_r, st_r, ov_r;
  logic [WIDTH-1:0] num_r, den_r;
  logic             oeq_r, ost_r;

  iter_cmd_t        it_cmd;
  logic [WIDTH-1:0] it_x, it_y, it_res, tb, sq;
  logic             it_done;

  rau_iter #(.WIDTH(WIDTH)) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kick_r),
    .cmd   (it_cmd),
    .x     (it_x),
    .y     (it_y),
    .done  (it_done),
    .res   (it_res)
  );

  assign out_valid = ov_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_eq    = oeq_r;
  assign out_st    = ost_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  // signed quotients of the lcm and simplify paths
  assign tb = (w_r[WIDTH-1] ^ bd_r[WIDTH-1]) ? -it_res : it_res;
  assign sq = (state_r == S_SN) ? (an_r[WIDTH-1] ? -it_res : it_res)
                                : (ad_r[WIDTH-1] ? -it_res : it_res);

  always_comb begin
    it_cmd = IT_MUL;
    it_x   = an_r;
    it_y   = bn_r;
    unique case (state_r)
      S_LG:  begin it_cmd = IT_GCD; it_x = mag(ad_r); it_y = mag(bd_r); end
      S_LQ:  begin it_cmd = IT_DIV; it_x = mag(ad_r); it_y = w_r;       end
      S_LL:  begin it_cmd = IT_MUL; it_x = w_r;       it_y = mag(bd_r); end
      S_LPA: begin it_cmd = IT_MUL; it_x = an_r;      it_y = l_r;       end
      S_LDA: begin it_cmd = IT_DIV; it_x = mag(w_r);  it_y = mag(ad_r); end
      S_LPB: begin it_cmd = IT_MUL; it_x = bn_r;      it_y = l_r;       end
      S_LDB: begin it_cmd = IT_DIV; it_x = mag(w_r);  it_y = mag(bd_r); end
      S_MN:  begin it_cmd = IT_MUL; it_x = an_r;      it_y = bn_r;      end
      S_MD:  begin it_cmd = IT_MUL; it_x = ad_r;      it_y = bd_r;      end
      S_SG:  begin it_cmd = IT_GCD; it_x = mag(ad_r); it_y = mag(an_r); end
      S_SN:  begin it_cmd = IT_DIV; it_x = mag(an_r); it_y = w_r;       end
      S_SD:  begin it_cmd = IT_DIV; it_x = mag(ad_r); it_y = w_r;       end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kick_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          kick_nxt = (q_ctl.kind != K_DIRECT);
          case (q_ctl.kind)
            K_LCM:   state_nxt = S_LG;
            K_MUL:   state_nxt = S_MN;
            K_SIMP:  state_nxt = S_SG;
            K_EQ:    state_nxt = S_SG;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_LG, S_LQ, S_LL, S_LPA, S_LDA, S_LPB, S_MN, S_SN: begin
        if (it_done) begin
          kick_nxt = 1'b1;
          case (state_r)
            S_LG:    state_nxt = S_LQ;
            S_LQ:    state_nxt = S_LL;
            S_LL:    state_nxt = S_LPA;
            S_LPA:   state_nxt = S_LDA;
            S_LDA:   state_nxt = S_LPB;
            S_LPB:   state_nxt = S_LDB;
            S_MN:    state_nxt = S_MD;
            default: state_nxt = S_SD;
          endcase
        end
      end
      S_LDB, S_MD: begin
        if (it_done) state_nxt = S_FIN;
      end
      S_SG: begin
        if (it_done) begin
          if (it_res != '0 && it_res != WIDTH'(1)) begin
            state_nxt = S_SN;
            kick_nxt  = 1'b1;
          end else begin
            state_nxt = S_SDONE;
          end
        end
      end
      S_SD: begin
        if (it_done) state_nxt = S_SDONE;
      end
      S_SDONE: begin
        if (kind_r == K_EQ && !phase_r) begin
          state_nxt = S_SG;
          kick_nxt  = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kick_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kick_r  <= kick_nxt;
      if (state_r == S_FIN && (!ov_r || !out_stall)) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          kind_r  <= q_ctl.kind;
          sub_r   <= q_ctl.sub;
          phase_r <= 1'b0;
          an_r    <= q_an;
          ad_r    <= q_ad;
          bn_r    <= q_bn;
          bd_r    <= q_bd;
          rn_r    <= q_an;
          rd_r    <= q_ad;
          st_r    <= q_ctl.st;
          eq_r    <= 1'b0;
        end
      end
      S_LG, S_LQ, S_LPA, S_LPB, S_SG: begin
        if (it_done) w_r <= it_res;
      end
      S_LL: begin
        if (it_done) l_r <= it_res;
      end
      S_LDA: begin
        if (it_done) t_r <= (w_r[WIDTH-1] ^ ad_r[WIDTH-1]) ? -it_res : it_res;
      end
      S_LDB: begin
        if (it_done) begin
          rn_r <= sub_r ? t_r - tb : t_r + tb;
          rd_r <= l_r;
          st_r <= (l_r == '0);
        end
      end
      S_MN: begin
        if (it_done) rn_r <= it_res;
      end
      S_MD: begin
        if (it_done) begin
          rd_r <= it_res;
          st_r <= (it_res == '0);
        end
      end
      S_SN: begin
        if (it_done) an_r <= sq;
      end
      S_SD: begin
        if (it_done) ad_r <= sq;
      end
      S_SDONE: begin
        if (kind_r == K_EQ) begin
          if (!phase_r) begin
            // park simplified a in b, simplify b next
            phase_r <= 1'b1;
            an_r    <= bn_r;
            ad_r    <= bd_r;
            bn_r    <= an_r;
            bd_r    <= ad_r;
          end else begin
            eq_r <= (an_r == bn_r) && (ad_r == bd_r);
            rn_r <= '0;
            rd_r <= WIDTH'(1);
            st_r <= 1'b0;
          end
        end else begin
          rn_r <= an_r;
          rd_r <= ad_r;
          st_r <= 1'b0;
        end
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          num_r <= rn_r;
          den_r <= rd_r;
          oeq_r <= eq_r;
          ost_r <= st_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/rau_checker.sv =====
// rau_checker: watches the input and result channels of the rational
// arithmetic unit, predicts each result and compares; depends on rau_pkg
`timescale 1ns / 1ps

module rau_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_res_num,
  input  logic [31:0] out_res_den,
  input  logic        out_is_equal,
  input  logic        out_status,
  output int          fail_count,
  output int          pending
);
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        eq;
    logic        st;
  } frac_res_t;

  frac_res_t expected_q[$];

  function automatic logic [31:0] mag(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function automatic logic [31:0] gcd_u(logic [31:0] u, logic [31:0] v);
    logic [31:0] t;
    while (v != 0) begin
      t = u % v;
      u = v;
      v = t;
    end
    return u;
  endfunction

  // divide by a magnitude, truncating toward zero
  function automatic logic [31:0] div_by_mag(logic [31:0] x, logic [31:0] g);
    logic [31:0] q;
    q = mag(x) / g;
    return x[31] ? -q : q;
  endfunction

  function automatic logic [31:0] sdiv_t(logic [31:0] x, logic [31:0] y);
    logic [31:0] q;
    q = mag(x) / mag(y);
    return (x[31] != y[31]) ? -q : q;
  endfunction

  function automatic void reduce(inout logic [31:0] n, inout logic [31:0] d);
    logic [31:0] g;
    g = gcd_u(mag(d), mag(n));
    if (g != 1 && g != 0) begin
      n = div_by_mag(n, g);
      d = div_by_mag(d, g);
    end
  endfunction

  function automatic frac_res_t predict_fraction(logic [2:0] op, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    frac_res_t r;
    logic [31:0] ma, mb, g, l, ta, tb;
    r = '{num: 32'd0, den: 32'd1, eq: 1'b0, st: 1'b0};
    if (op <= OP_EQ && (ad == 0 || (op != OP_SIMP && bd == 0))) begin
      r.den = 0;
      r.st = 1'b1;
    end else if (op == OP_ADD || op == OP_SUB) begin
      if (ad == bd) begin
        r.num = (op == OP_ADD) ? an + bn : an - bn;
        r.den = ad;
      end else begin
        ma = mag(ad);
        mb = mag(bd);
        g = gcd_u(ma, mb);
        l = (ma / g) * mb;
        ta = sdiv_t(an * l, ad);
        tb = sdiv_t(bn * l, bd);
        r.num = (op == OP_ADD) ? ta + tb : ta - tb;
        r.den = l;
      end
      r.st = (r.den == 0);
    end else if (op == OP_MUL) begin
      r.num = an * bn;
      r.den = ad * bd;
      r.st = (r.den == 0);
    end else if (op == OP_DIV) begin
      r.num = an * bd;
      r.den = ad * bn;
      r.st = (r.den == 0);
    end else if (op == OP_SIMP) begin
      r.num = an;
      r.den = ad;
      reduce(r.num, r.den);
    end else if (op == OP_EQ) begin
      reduce(an, ad);
      reduce(bn, bd);
      r.eq = (an == bn && ad == bd);
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    frac_res_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(predict_fraction(in_op, in_a_num, in_a_den,
                                              in_b_num, in_b_den));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result num=%h den=%h eq=%b st=%b", $time,
                   out_res_num, out_res_den, out_is_equal, out_status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.num !== out_res_num || e.den !== out_res_den ||
              e.eq !== out_is_equal || e.st !== out_status) begin
            $display("%0t: mismatch expected num=%h den=%h eq=%b st=%b",
                     $time, e.num, e.den, e.eq, e.st);
            $display("%0t:          actual   num=%h den=%h eq=%b st=%b",
                     $time, out_res_num, out_res_den, out_is_equal, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: drives random and directed fraction items into the rational
// arithmetic unit with random gaps and stalls; depends on rau_pkg, rau_checker
`timescale 1ns / 1ps

module testbench;
  import rau_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_op;
  logic [31:0] in_a_num, in_a_den, in_b_num, in_b_den;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_res_num, out_res_den;
  logic        out_is_equal, out_status;
  int          fail_count;
  int          pending;

  rational_arithmetic_unit_top i_dut (.*);

  rau_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver stalls a random number of cycles before each result
  initial begin
    int wait_left;
    out_stall = 1'b1;
    wait_left = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) wait_left = $urandom_range(0, 10);
      if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom;
      5: return -$urandom_range(1, 100);
      default: return $urandom_range(1, 100) * $urandom_range(1, 12);
    endcase
  endfunction

  task automatic send_fraction(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [31:0] n, d;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ADD;
    in_a_num = 0;
    in_a_den = 1;
    in_b_num = 0;
    in_b_den = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every op, zero denominators, extremes, unused codes
    send_fraction(OP_ADD, 1, 2, 1, 3);
    send_fraction(OP_ADD, 3, 4, 5, 4);
    send_fraction(OP_SUB, 3, 4, 5, 4);
    send_fraction(OP_SUB, 1, -6, 1, 4);
    send_fraction(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 2);
    send_fraction(OP_DIV, 7, 3, 0, 5);
    send_fraction(OP_DIV, 32'h8000_0000, -1, 32'h8000_0000, 3);
    send_fraction(OP_SIMP, 12, -18, 0, 0);
    send_fraction(OP_SIMP, 0, 32'h8000_0000, 5, 5);
    send_fraction(OP_SIMP, 32'h8000_0000, 32'h8000_0000, 1, 1);
    send_fraction(OP_EQ, 2, 4, 1, 2);
    send_fraction(OP_EQ, -1, 2, 1, -2);
    send_fraction(OP_EQ, 0, 3, 0, 7);
    send_fraction(OP_ADD, 1, 0, 1, 1);
    send_fraction(OP_MUL, 1, 1, 1, 0);
    send_fraction(OP_SIMP, 1, 0, 1, 1);
    send_fraction(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_fraction(OP_MUL, 1, 32'h1_0000, 1, 32'h1_0000);
    send_fraction(3'd6, 1, 2, 3, 4);
    send_fraction(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    repeat (1200) begin
      n = pick_value();
      d = pick_value();
      if ($urandom_range(0, 3) == 0)
        send_fraction(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 2) == 0)
        send_fraction(3'($urandom_range(0, 5)), n, d, n * $urandom_range(1, 5),
                      d * $urandom_range(1, 5));
      else
        send_fraction(3'($urandom_range(0, 5)), pick_value(), pick_value(),
                      pick_value(), pick_value());
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rau_pkg.sv
hdl/rau_front.sv
hdl/rau_queue.sv
hdl/rau_iter.sv
hdl/rau_back.sv
hdl/rational_arithmetic_unit_top.sv
tb/sv/rau_checker.sv
tb/sv/testbench.sv
